### rtl/staged_mass_dosing_controller_macros.svh
// assertion helpers used by the dosing controller top level
`ifndef STAGED_MASS_DOSING_CONTROLLER_MACROS_SVH
`define STAGED_MASS_DOSING_CONTROLLER_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define SMDC_ASSERT_NOW(label, clk, rst_n, trig, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error("dosing controller check failed");

// property that must hold in the cycle after its trigger
`define SMDC_ASSERT_NEXT(label, clk, rst_n, trig, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("dosing controller check failed");

`endif

### rtl/smdc_pkg.sv
package smdc_pkg;

  localparam int unsigned STEP_GAP_MS_DEF = 50;

  localparam int unsigned MASS_W   = 24;
  localparam int unsigned TARGET_W = 23;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned OPEN_W   = 9;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic [OPEN_W-1:0] OPEN_FULL = OPEN_W'(256);
  localparam logic [OPEN_W-1:0] WEIGHT_MIN = OPEN_W'(3);

  localparam logic [TARGET_W-1:0] TARGET_RST    = '0;
  localparam logic [DIST_W-1:0]   TAPER_RST     = DIST_W'(2048);
  localparam logic [DIST_W-1:0]   FINAL_RST     = DIST_W'(512);
  localparam logic [DIST_W-1:0]   OVERSHOOT_RST = DIST_W'(179);
  localparam logic [OPEN_W-1:0]   FAST_OPEN_RST  = OPEN_W'(256);
  localparam logic [OPEN_W-1:0]   TAPER_OPEN_RST = OPEN_W'(102);
  localparam logic [OPEN_W-1:0]   FINAL_OPEN_RST = OPEN_W'(38);
  localparam logic [OPEN_W-1:0]   WEIGHT_RST     = OPEN_W'(64);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRIME   = 3'd1,
    PH_FAST    = 3'd2,
    PH_TAPER   = 3'd3,
    PH_FINAL   = 3'd4,
    PH_DONE    = 3'd5,
    PH_ABORTED = 3'd6,
    PH_ERROR   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_SENSOR   = 2'd2,
    ST_ACTUATOR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_ABORT = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_MASS      = 3'd0,
    CFG_TAPER_DISTANCE   = 3'd1,
    CFG_FINAL_BAND       = 3'd2,
    CFG_OVERSHOOT_MARGIN = 3'd3,
    CFG_FAST_OPENING     = 3'd4,
    CFG_TAPER_OPENING    = 3'd5,
    CFG_FINAL_OPENING    = 3'd6,
    CFG_SMOOTHING_WEIGHT = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target_mass;
    logic [DIST_W-1:0]   taper_distance;
    logic [DIST_W-1:0]   final_band;
    logic [DIST_W-1:0]   overshoot_margin;
    logic [OPEN_W-1:0]   fast_opening;
    logic [OPEN_W-1:0]   taper_opening;
    logic [OPEN_W-1:0]   final_opening;
    logic [OPEN_W-1:0]   smoothing_weight;
  } cfg_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [MASS_W-1:0] mass_sample;
    logic                     sample_fault;
    logic                     actuator_fault;
    logic [TIME_W-1:0]        time_ms;
  } item_t;

  typedef struct packed {
    logic [OPEN_W-1:0]        flap_opening;
    logic                     flap_write;
    phase_t                   phase;
    logic                     running;
    status_t                  status;
    logic                     stop_request;
    logic signed [MASS_W-1:0] filtered_mass;
  } res_t;

  function automatic logic [OPEN_W-1:0] sat_open(input logic [OPEN_W-1:0] v);
    sat_open = (v > OPEN_FULL) ? OPEN_FULL : v;
  endfunction

endpackage

### rtl/smdc_filter.sv
module smdc_filter (
  input  logic signed [smdc_pkg::MASS_W-1:0] sample,
  input  logic signed [smdc_pkg::MASS_W-1:0] old_mass,
  input  logic [smdc_pkg::OPEN_W-1:0]        weight,
  output logic signed [smdc_pkg::MASS_W-1:0] mixed
);
  import smdc_pkg::*;

  localparam int unsigned DIFF_W = MASS_W + 1;
  localparam int unsigned SUM_W  = DIFF_W + OPEN_W + 1;

  logic [OPEN_W-1:0]        a;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SUM_W-1:0]  prod;
  logic signed [SUM_W-1:0]  base;
  logic signed [SUM_W-1:0]  sum;

  // clamp weight to 3..256
  always_comb begin
    if (weight < WEIGHT_MIN) begin
      a = WEIGHT_MIN;
    end else if (weight > OPEN_FULL) begin
      a = OPEN_FULL;
    end else begin
      a = weight;
    end
  end

  // a*s + (256-a)*o == 256*o + a*(s-o), one multiplier
  assign diff = DIFF_W'(sample) - DIFF_W'(old_mass);
  assign prod = SUM_W'(diff) * SUM_W'($signed({1'b0, a}));
  assign base = SUM_W'($signed({old_mass, 8'b0}));
  assign sum  = base + prod + SUM_W'(128);

  // arithmetic shift by 8 floors toward minus infinity
  assign mixed = sum[MASS_W+7:8];

endmodule

### rtl/smdc_core.sv
module smdc_core #(
  parameter int unsigned STEP_GAP_MS = smdc_pkg::STEP_GAP_MS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  smdc_pkg::item_t item,
  input  smdc_pkg::cfg_t  cfg,
  output smdc_pkg::res_t  res
);
  import smdc_pkg::*;

  localparam int unsigned CMP_W = MASS_W + 2;

  phase_t                   phase_r, phase_nxt;
  logic signed [MASS_W-1:0] smoothed_r, smoothed_nxt;
  logic [TIME_W-1:0]        last_step_r, last_step_nxt;
  logic                     step_valid_r, step_valid_nxt;
  logic                     have_r, have_nxt;
  status_t                  err_r, err_nxt;

  logic signed [MASS_W-1:0] mixed;
  logic signed [MASS_W-1:0] f_tick;
  logic signed [CMP_W-1:0]  f_ext, tgt_ext, over_lim, remain;
  logic [TIME_W-1:0]        dt;
  logic                     throttled;
  logic                     running_now;
  phase_t                   step_phase;
  logic [OPEN_W-1:0]        step_open;
  logic [OPEN_W-1:0]        open;
  logic                     write, stop, reject;

  smdc_filter u_filter (
    .sample   (item.mass_sample),
    .old_mass (smoothed_r),
    .weight   (cfg.smoothing_weight),
    .mixed    (mixed)
  );

  assign f_tick    = have_r ? mixed : item.mass_sample;
  assign f_ext     = CMP_W'(f_tick);
  assign tgt_ext   = $signed({{(CMP_W-TARGET_W){1'b0}}, cfg.target_mass});
  assign over_lim  = tgt_ext + $signed({{(CMP_W-DIST_W){1'b0}}, cfg.overshoot_margin});
  assign remain    = tgt_ext - f_ext;
  assign dt        = item.time_ms - last_step_r;
  assign throttled = step_valid_r && (dt < TIME_W'(STEP_GAP_MS));
  assign running_now = (phase_r >= PH_PRIME) && (phase_r <= PH_FINAL);

  // phase advance when a step is due
  always_comb begin
    step_phase = phase_r;
    step_open  = '0;
    case (phase_r)
      PH_PRIME: begin
        step_open  = cfg.fast_opening;
        step_phase = PH_FAST;
      end
      PH_FAST: begin
        if (remain <= $signed({{(CMP_W-DIST_W){1'b0}}, cfg.taper_distance})) begin
          step_open  = cfg.taper_opening;
          step_phase = PH_TAPER;
        end else begin
          step_open  = cfg.fast_opening;
        end
      end
      PH_TAPER: begin
        if (remain <= $signed({{(CMP_W-DIST_W){1'b0}}, cfg.final_band})) begin
          step_open  = cfg.final_opening;
          step_phase = PH_FINAL;
        end else begin
          step_open  = cfg.taper_opening;
        end
      end
      default: begin
        if (f_ext >= tgt_ext) begin
          step_open  = '0;
          step_phase = PH_DONE;
        end else begin
          step_open  = cfg.final_opening;
        end
      end
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    smoothed_nxt   = smoothed_r;
    last_step_nxt  = last_step_r;
    step_valid_nxt = step_valid_r;
    have_nxt       = have_r;
    err_nxt        = err_r;
    open           = '0;
    write          = 1'b0;
    stop           = 1'b0;
    reject         = 1'b0;
    case (req_t'(item.req_type))
      REQ_START: begin
        if (cfg.target_mass == '0) begin
          reject = 1'b1;
        end else begin
          smoothed_nxt   = '0;
          last_step_nxt  = '0;
          step_valid_nxt = 1'b0;
          have_nxt       = 1'b0;
          err_nxt        = ST_OK;
          phase_nxt      = PH_PRIME;
        end
      end
      REQ_ABORT: begin
        write = 1'b1;
        if (item.actuator_fault) begin
          phase_nxt = PH_ERROR;
          err_nxt   = ST_ACTUATOR;
        end else begin
          phase_nxt = PH_ABORTED;
          stop      = 1'b1;
        end
      end
      REQ_TICK: begin
        if (running_now) begin
          if (item.sample_fault) begin
            phase_nxt = PH_ERROR;
            err_nxt   = ST_SENSOR;
            write     = 1'b1;
          end else begin
            smoothed_nxt = f_tick;
            have_nxt     = 1'b1;
            if (f_ext > over_lim) begin
              phase_nxt = PH_DONE;
              write     = 1'b1;
            end else if (!throttled) begin
              write = 1'b1;
              if (item.actuator_fault) begin
                phase_nxt = PH_ERROR;
                err_nxt   = ST_ACTUATOR;
              end else begin
                open           = sat_open(step_open);
                phase_nxt      = step_phase;
                last_step_nxt  = item.time_ms;
                step_valid_nxt = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.flap_opening  = open;
    res.flap_write    = write;
    res.phase         = phase_nxt;
    res.running       = (phase_nxt >= PH_PRIME) && (phase_nxt <= PH_FINAL);
    res.status        = reject ? ST_REJECT : err_nxt;
    res.stop_request  = stop;
    res.filtered_mass = smoothed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      smoothed_r   <= '0;
      last_step_r  <= '0;
      step_valid_r <= 1'b0;
      have_r       <= 1'b0;
      err_r        <= ST_OK;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      smoothed_r   <= smoothed_nxt;
      last_step_r  <= last_step_nxt;
      step_valid_r <= step_valid_nxt;
      have_r       <= have_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

### rtl/staged_mass_dosing_controller.sv
// Staged gravimetric dosing controller. Each item is a start, an abort or a
// timestamped load cell sample; every item gives exactly one result item with
// the flap command, the phase, the status and the smoothed mass. The block
// takes one item per clock while the result side is not stalled: an item is
// captured in an input register, then the filter (a single 10x25 multiply-add)
// and the phase logic settle against the held state and load the result
// register that drives the outputs. A stalled result only holds back the
// input side once both registers are full. Configuration is reset to its
// documented defaults and needs no initialization pass.
module staged_mass_dosing_controller #(
  parameter int unsigned STEP_GAP_MS = smdc_pkg::STEP_GAP_MS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [smdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smdc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // item input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic signed [smdc_pkg::MASS_W-1:0]  in_mass_sample,
  input  logic                                in_sample_fault,
  input  logic                                in_actuator_fault,
  input  logic [smdc_pkg::TIME_W-1:0]         in_time_ms,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [smdc_pkg::OPEN_W-1:0]         out_flap_opening,
  output logic                                out_flap_write,
  output logic [2:0]                          out_phase,
  output logic                                out_running,
  output logic [1:0]                          out_status,
  output logic                                out_stop_request,
  output logic signed [smdc_pkg::MASS_W-1:0]  out_filtered_mass
);
  import smdc_pkg::*;
  `include "staged_mass_dosing_controller_macros.svh"

  cfg_t  cfg_r, cfg_nxt;
  item_t item_r;
  logic  pipe_valid_r;
  res_t  res_r, res_c;
  logic  out_valid_r;
  logic  advance;
  logic  in_take;

  // configuration registers: user writes only while quiet, block does not check
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TARGET_MASS:      cfg_nxt.target_mass      = cfg_wdata[TARGET_W-1:0];
        CFG_TAPER_DISTANCE:   cfg_nxt.taper_distance   = cfg_wdata[DIST_W-1:0];
        CFG_FINAL_BAND:       cfg_nxt.final_band       = cfg_wdata[DIST_W-1:0];
        CFG_OVERSHOOT_MARGIN: cfg_nxt.overshoot_margin = cfg_wdata[DIST_W-1:0];
        CFG_FAST_OPENING:     cfg_nxt.fast_opening     = cfg_wdata[OPEN_W-1:0];
        CFG_TAPER_OPENING:    cfg_nxt.taper_opening    = cfg_wdata[OPEN_W-1:0];
        CFG_FINAL_OPENING:    cfg_nxt.final_opening    = cfg_wdata[OPEN_W-1:0];
        CFG_SMOOTHING_WEIGHT: cfg_nxt.smoothing_weight = cfg_wdata[OPEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_mass      <= TARGET_RST;
      cfg_r.taper_distance   <= TAPER_RST;
      cfg_r.final_band       <= FINAL_RST;
      cfg_r.overshoot_margin <= OVERSHOOT_RST;
      cfg_r.fast_opening     <= FAST_OPEN_RST;
      cfg_r.taper_opening    <= TAPER_OPEN_RST;
      cfg_r.final_opening    <= FINAL_OPEN_RST;
      cfg_r.smoothing_weight <= WEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // the held item moves on when the result register is free or draining
  assign advance  = pipe_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = pipe_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_valid_r <= 1'b0;
    end else begin
      pipe_valid_r <= in_take || (pipe_valid_r && !advance);
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.req_type       <= in_req_type;
      item_r.mass_sample    <= in_mass_sample;
      item_r.sample_fault   <= in_sample_fault;
      item_r.actuator_fault <= in_actuator_fault;
      item_r.time_ms        <= in_time_ms;
    end
  end

  // filter, phase sequencer and run state
  smdc_core #(
    .STEP_GAP_MS (STEP_GAP_MS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= advance || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_flap_opening  = res_r.flap_opening;
  assign out_flap_write    = res_r.flap_write;
  assign out_phase         = res_r.phase;
  assign out_running       = res_r.running;
  assign out_status        = res_r.status;
  assign out_stop_request  = res_r.stop_request;
  assign out_filtered_mass = res_r.filtered_mass;

  // no opening without a flap command, and never above fully open
  `SMDC_ASSERT_NOW(a_open_needs_write, clk, rst_n, out_valid_r,
    out_flap_write || (out_flap_opening == '0))
  `SMDC_ASSERT_NOW(a_open_range, clk, rst_n, out_valid_r, out_flap_opening <= OPEN_FULL)
  // running flag follows the phase
  `SMDC_ASSERT_NOW(a_running_phase, clk, rst_n, out_valid_r,
    out_running == ((out_phase >= PH_PRIME) && (out_phase <= PH_FINAL)))
  // a stop message is only asked for on a clean abort
  `SMDC_ASSERT_NOW(a_stop_aborted, clk, rst_n, out_valid_r && out_stop_request,
    (out_phase == PH_ABORTED) && out_flap_write)
  // an item that moves on always lands in the result register
  `SMDC_ASSERT_NEXT(a_advance_lands, clk, rst_n, advance, out_valid_r)

endmodule

### tb/tb.sv
module tb;
  import smdc_pkg::*;

  // request code the block must ignore
  localparam logic [1:0] REQ_SPARE = 2'd3;
  // live items per random register setting
  localparam int unsigned PHASE_ITEMS = 165;
  // length of the long receiver hold-off
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned STEP_MS = STEP_GAP_MS_DEF;

  // every input starts at a known value
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_req_type = '0;
  logic signed [MASS_W-1:0] in_mass_sample = '0;
  logic                    in_sample_fault = 1'b0;
  logic                    in_actuator_fault = 1'b0;
  logic [TIME_W-1:0]       in_time_ms = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [OPEN_W-1:0]       out_flap_opening;
  logic                    out_flap_write;
  logic [2:0]              out_phase;
  logic                    out_running;
  logic [1:0]              out_status;
  logic                    out_stop_request;
  logic signed [MASS_W-1:0] out_filtered_mass;

  staged_mass_dosing_controller dut (
    .clk, .rst_n,
    .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_req_type, .in_mass_sample, .in_sample_fault,
    .in_actuator_fault, .in_time_ms,
    .out_valid, .out_stall, .out_flap_opening, .out_flap_write, .out_phase,
    .out_running, .out_status, .out_stop_request, .out_filtered_mass
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one row of the directed plan: a register write or an item
  typedef struct {
    bit       is_cfg;
    cfg_idx_t reg_idx;
    int unsigned reg_val;
    item_t    it;
    bit       known;
    res_t     res;
  } dir_row_t;

  dir_row_t plan[$];
  res_t     expected_doses[$];

  // predictor state and its copy of the registers
  phase_t                   dose_phase;
  logic signed [MASS_W-1:0] dose_avg;
  logic [TIME_W-1:0]        dose_step_time;
  status_t                  dose_err;
  bit                       dose_have;
  bit                       dose_stepped;
  logic [TARGET_W-1:0]      reg_target;
  logic [DIST_W-1:0]        reg_taper_dist, reg_final_band, reg_overshoot;
  logic [OPEN_W-1:0]        reg_fast_open, reg_taper_open, reg_final_open, reg_weight;

  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned live_items, results_seen, mismatches;
  bit          hold_req;

  function automatic bit dose_running();
    return dose_phase >= PH_PRIME && dose_phase <= PH_FINAL;
  endfunction

  // exponential average, weight clamped to 3..256, floor of the biased sum
  function automatic logic signed [MASS_W-1:0] blend(input logic signed [MASS_W-1:0] s,
                                                      input logic signed [MASS_W-1:0] old);
    longint a, sum;
    a = reg_weight;
    if (a < 3) a = 3;
    if (a > 256) a = 256;
    sum = a * longint'(s) + (256 - a) * longint'(old) + 128;
    return MASS_W'(sum >>> 8);
  endfunction

  // advances the predictor by one item and returns the result item it causes
  function automatic res_t predict_dose(input item_t it);
    res_t              r;
    logic [OPEN_W-1:0] opening;
    bit                wr, stop, rej, run_now;
    phase_t            nxt;
    longint            f, tgt, remain;
    logic [TIME_W-1:0] dt;
    opening = '0;
    wr = 1'b0;
    stop = 1'b0;
    rej = 1'b0;
    run_now = dose_running();
    case (it.req_type)
      REQ_START: begin
        if (reg_target == '0) begin
          rej = 1'b1;
        end else begin
          dose_avg = '0;
          dose_have = 1'b0;
          dose_stepped = 1'b0;
          dose_step_time = '0;
          dose_err = ST_OK;
          dose_phase = PH_PRIME;
        end
      end
      REQ_ABORT: begin
        wr = 1'b1;
        if (it.actuator_fault) begin
          dose_phase = PH_ERROR;
          dose_err = ST_ACTUATOR;
        end else begin
          dose_phase = PH_ABORTED;
          stop = 1'b1;
        end
      end
      REQ_TICK: begin
        if (run_now && it.sample_fault) begin
          dose_phase = PH_ERROR;
          dose_err = ST_SENSOR;
          wr = 1'b1;
        end else if (run_now) begin
          dose_avg = dose_have ? blend($signed(it.mass_sample), dose_avg)
                               : $signed(it.mass_sample);
          dose_have = 1'b1;
          f = dose_avg;
          tgt = reg_target;
          remain = tgt - f;
          dt = it.time_ms - dose_step_time;
          if (f > tgt + longint'(reg_overshoot)) begin
            // overshoot: hard stop, actuator fault not looked at
            dose_phase = PH_DONE;
            wr = 1'b1;
          end else if (!(dose_stepped && dt < STEP_MS)) begin
            nxt = dose_phase;
            case (dose_phase)
              PH_PRIME: begin
                opening = reg_fast_open;
                nxt = PH_FAST;
              end
              PH_FAST: begin
                if (remain <= longint'(reg_taper_dist)) begin
                  opening = reg_taper_open;
                  nxt = PH_TAPER;
                end else begin
                  opening = reg_fast_open;
                end
              end
              PH_TAPER: begin
                if (remain <= longint'(reg_final_band)) begin
                  opening = reg_final_open;
                  nxt = PH_FINAL;
                end else begin
                  opening = reg_taper_open;
                end
              end
              default: begin
                if (f >= tgt) begin
                  opening = '0;
                  nxt = PH_DONE;
                end else begin
                  opening = reg_final_open;
                end
              end
            endcase
            wr = 1'b1;
            if (it.actuator_fault) begin
              dose_phase = PH_ERROR;
              dose_err = ST_ACTUATOR;
              opening = '0;
            end else begin
              if (opening > OPEN_W'(256)) opening = OPEN_W'(256);
              dose_phase = nxt;
              dose_step_time = it.time_ms;
              dose_stepped = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.flap_opening = wr ? opening : '0;
    r.flap_write = wr;
    r.phase = dose_phase;
    r.running = dose_running();
    r.status = rej ? ST_REJECT : dose_err;
    r.stop_request = stop;
    r.filtered_mass = dose_avg;
    return r;
  endfunction

  function automatic item_t make_item(input logic [1:0] req, input logic [31:0] m,
                                      input bit sf, input bit af, input logic [31:0] t);
    item_t it;
    it.req_type = req;
    it.mass_sample = m[MASS_W-1:0];
    it.sample_fault = sf;
    it.actuator_fault = af;
    it.time_ms = t;
    return it;
  endfunction

  function automatic res_t make_res(input int opening, input bit wr, input phase_t ph,
                                    input bit run, input status_t st, input bit stop,
                                    input int mass);
    res_t r;
    r.flap_opening = opening[OPEN_W-1:0];
    r.flap_write = wr;
    r.phase = ph;
    r.running = run;
    r.status = st;
    r.stop_request = stop;
    r.filtered_mass = mass[MASS_W-1:0];
    return r;
  endfunction

  task automatic plan_cfg(input cfg_idx_t idx, input int unsigned val);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.known = 1'b0;
    plan.push_back(row);
  endtask

  task automatic plan_item(input logic [1:0] req, input int m, input bit sf, input bit af,
                           input logic [31:0] t);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.it = make_item(req, m, sf, af, t);
    row.known = 1'b0;
    plan.push_back(row);
  endtask

  // item whose result is obvious enough to write down directly
  task automatic plan_known(input logic [1:0] req, input int m, input bit sf, input bit af,
                            input logic [31:0] t, input res_t e);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.it = make_item(req, m, sf, af, t);
    row.known = 1'b1;
    row.res = e;
    plan.push_back(row);
  endtask

  task automatic set_pace(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // offer one item, with random idle cycles ahead of it, and log its expected result
  task automatic offer_item(input item_t it, input bit known, input res_t typed);
    res_t calc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req_type;
    in_mass_sample <= it.mass_sample;
    in_sample_fault <= it.sample_fault;
    in_actuator_fault <= it.actuator_fault;
    in_time_ms <= it.time_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // ticks while not running and the spare code are only echoed
    if (it.req_type == REQ_START || it.req_type == REQ_ABORT ||
        (it.req_type == REQ_TICK && dose_running()))
      live_items++;
    calc = predict_dose(it);
    expected_doses.push_back(known ? typed : calc);
  endtask

  // stop offering and wait for every outstanding result plus the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_doses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TARGET_MASS:      reg_target = val[TARGET_W-1:0];
      CFG_TAPER_DISTANCE:   reg_taper_dist = val[DIST_W-1:0];
      CFG_FINAL_BAND:       reg_final_band = val[DIST_W-1:0];
      CFG_OVERSHOOT_MARGIN: reg_overshoot = val[DIST_W-1:0];
      CFG_FAST_OPENING:     reg_fast_open = val[OPEN_W-1:0];
      CFG_TAPER_OPENING:    reg_taper_open = val[OPEN_W-1:0];
      CFG_FINAL_OPENING:    reg_final_open = val[OPEN_W-1:0];
      default:              reg_weight = val[OPEN_W-1:0];
    endcase
  endtask

  task automatic program_all(input int unsigned tgt, input int unsigned taper,
                             input int unsigned band, input int unsigned over,
                             input int unsigned fast, input int unsigned tapo,
                             input int unsigned fino, input int unsigned wt);
    write_reg(CFG_TARGET_MASS, tgt);
    write_reg(CFG_TAPER_DISTANCE, taper);
    write_reg(CFG_FINAL_BAND, band);
    write_reg(CFG_OVERSHOOT_MARGIN, over);
    write_reg(CFG_FAST_OPENING, fast);
    write_reg(CFG_TAPER_OPENING, tapo);
    write_reg(CFG_FINAL_OPENING, fino);
    write_reg(CFG_SMOOTHING_WEIGHT, wt);
  endtask

  // one dosing run: a start, then samples climbing toward the target with
  // random timing, occasional faults, aborts, restarts and spare codes,
  // followed by a little noise once the run ends or 45 items have been offered
  task automatic dose_batch();
    item_t             it;
    longint            lvl, step, mv;
    logic [TIME_W-1:0] now;
    logic [1:0]        req;
    int                n, roll, gap_roll, back, div;
    now = $urandom();
    div = $urandom_range(6, 20);
    step = longint'(reg_target) / div;
    if (step < 1) step = 1;
    back = $urandom_range(0, 3);
    lvl = -(step * back) / 2;
    it = make_item(REQ_START, $urandom(), $urandom_range(1), $urandom_range(1), now);
    offer_item(it, 1'b0, '0);
    n = 0;
    while (n < 45 && dose_running()) begin
      roll = $urandom_range(99);
      gap_roll = $urandom_range(99);
      // mostly legal step spacing, some throttled, a few wild jumps
      if (gap_roll < 15) now += $urandom_range(0, STEP_MS - 1);
      else if (gap_roll < 20) now = $urandom();
      else now += $urandom_range(STEP_MS, 300);
      if (roll < 2) begin
        it = make_item(REQ_ABORT, $urandom(), $urandom_range(1), $urandom_range(3) == 0, now);
      end else if (roll < 4) begin
        it = make_item(REQ_START, $urandom(), $urandom_range(1), $urandom_range(1), now);
      end else if (roll < 6) begin
        it = make_item(REQ_SPARE, $urandom(), $urandom_range(1), $urandom_range(1), now);
      end else begin
        if (roll < 10) begin
          mv = longint'($signed(MASS_W'($urandom())));
        end else begin
          mv = lvl + longint'($urandom_range(0, 64)) - 32;
          if (mv > 8388607) mv = 8388607;
          if (mv < -8388608) mv = -8388608;
        end
        it = make_item(REQ_TICK, 32'(mv), $urandom_range(99) < 2, $urandom_range(99) < 3,
                       now);
      end
      offer_item(it, 1'b0, '0);
      lvl += step;
      n++;
    end
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(2))
        0:       req = REQ_TICK;
        1:       req = REQ_SPARE;
        default: req = REQ_ABORT;
      endcase
      it = make_item(req, $urandom(), $urandom_range(1), $urandom_range(1), $urandom());
      offer_item(it, 1'b0, '0);
    end
  endtask

  task automatic flag_failure(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at %0t", what, $time);
      $display("  expected: open %0d write %0d phase %0d running %0d status %0d stop %0d mass %0d",
               want.flap_opening, want.flap_write, want.phase, want.running, want.status,
               want.stop_request, $signed(want.filtered_mass));
      $display("  actual:   open %0d write %0d phase %0d running %0d status %0d stop %0d mass %0d",
               got.flap_opening, got.flap_write, got.phase, got.running, got.status,
               got.stop_request, $signed(got.filtered_mass));
    end
  endtask

  // result side: check each accepted result and pick the stall for the next edge
  initial begin : result_side
    res_t want, got;
    int   hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.flap_opening = out_flap_opening;
        got.flap_write = out_flap_write;
        got.phase = phase_t'(out_phase);
        got.running = out_running;
        got.status = status_t'(out_status);
        got.stop_request = out_stop_request;
        got.filtered_mass = out_filtered_mass;
        results_seen++;
        if (expected_doses.size() == 0) begin
          flag_failure("result item with nothing expected", got, got);
        end else begin
          want = expected_doses.pop_front();
          if (want.flap_opening !== got.flap_opening || want.flap_write !== got.flap_write ||
              want.phase !== got.phase || want.running !== got.running ||
              want.status !== got.status || want.stop_request !== got.stop_request ||
              want.filtered_mass !== got.filtered_mass)
            flag_failure("result item mismatch", want, got);
        end
      end
      // long hold-off so the block fills and stalls its input
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int  p, goal, dir_items;
    bit  in_cfg, held, paused;
    // predictor reset, registers at their documented defaults
    dose_phase = PH_IDLE;
    dose_avg = '0;
    dose_step_time = '0;
    dose_err = ST_OK;
    dose_have = 1'b0;
    dose_stepped = 1'b0;
    reg_target = TARGET_RST;
    reg_taper_dist = TAPER_RST;
    reg_final_band = FINAL_RST;
    reg_overshoot = OVERSHOOT_RST;
    reg_fast_open = FAST_OPEN_RST;
    reg_taper_open = TAPER_OPEN_RST;
    reg_final_open = FINAL_OPEN_RST;
    reg_weight = WEIGHT_RST;
    live_items = 0;
    results_seen = 0;
    mismatches = 0;
    hold_req = 1'b0;
    held = 1'b0;
    paused = 1'b0;
    in_cfg = 1'b0;
    dir_items = 0;
    set_pace(9, 70);

    // target still zero after reset: start rejected, idle ticks and spare echoed
    plan_known(REQ_START, 0, 0, 0, 0, make_res(0, 0, PH_IDLE, 0, ST_REJECT, 0, 0));
    plan_known(REQ_TICK, 8388607, 1, 1, 32'hFFFF_FFFF,
               make_res(0, 0, PH_IDLE, 0, ST_OK, 0, 0));
    plan_known(REQ_SPARE, -8388608, 1, 1, 0, make_res(0, 0, PH_IDLE, 0, ST_OK, 0, 0));
    // abort from idle, clean and with a failing flap
    plan_known(REQ_ABORT, 0, 0, 0, 0, make_res(0, 1, PH_ABORTED, 0, ST_OK, 1, 0));
    plan_known(REQ_ABORT, 0, 0, 1, 0, make_res(0, 1, PH_ERROR, 0, ST_ACTUATOR, 0, 0));
    // fast and taper openings above full scale, full weight so the average follows the sample
    plan_cfg(CFG_TARGET_MASS, 6000);
    plan_cfg(CFG_TAPER_DISTANCE, 3000);
    plan_cfg(CFG_FINAL_BAND, 1000);
    plan_cfg(CFG_OVERSHOOT_MARGIN, 200);
    plan_cfg(CFG_FAST_OPENING, 511);
    plan_cfg(CFG_TAPER_OPENING, 300);
    plan_cfg(CFG_FINAL_OPENING, 0);
    plan_cfg(CFG_SMOOTHING_WEIGHT, 256);
    // full run through every phase, with a throttled step and a time wrap
    plan_known(REQ_START, 0, 0, 0, 0, make_res(0, 0, PH_PRIME, 1, ST_OK, 0, 0));
    plan_known(REQ_TICK, 0, 0, 0, 100, make_res(256, 1, PH_FAST, 1, ST_OK, 0, 0));
    plan_known(REQ_TICK, 1000, 0, 0, 120, make_res(0, 0, PH_FAST, 1, ST_OK, 0, 1000));
    plan_item(REQ_TICK, 3000, 0, 0, 150);
    plan_item(REQ_TICK, 5000, 0, 0, 200);
    plan_item(REQ_TICK, 5999, 0, 0, 32'hFFFF_FFF0);
    plan_item(REQ_TICK, 6000, 0, 0, 32'h0000_0010);
    plan_item(REQ_TICK, 6000, 0, 0, 32'h0000_0030);
    plan_item(REQ_TICK, 1, 0, 0, 32'h0000_1000);
    // sensor fault wins over actuator fault
    plan_known(REQ_START, 0, 0, 0, 0, make_res(0, 0, PH_PRIME, 1, ST_OK, 0, 0));
    plan_known(REQ_TICK, -8388608, 1, 1, 0, make_res(0, 1, PH_ERROR, 0, ST_SENSOR, 0, 0));
    // overshoot ignores the actuator fault
    plan_item(REQ_START, 0, 0, 0, 0);
    plan_known(REQ_TICK, 8388607, 0, 1, 3, make_res(0, 1, PH_DONE, 0, ST_OK, 0, 8388607));
    // actuator fault on a step command
    plan_item(REQ_START, 0, 0, 0, 0);
    plan_known(REQ_TICK, 100, 0, 1, 5, make_res(0, 1, PH_ERROR, 0, ST_ACTUATOR, 0, 100));
    // abort while running
    plan_item(REQ_START, 0, 0, 0, 0);
    plan_item(REQ_TICK, 100, 0, 0, 7);
    plan_known(REQ_ABORT, 0, 0, 0, 8, make_res(0, 1, PH_ABORTED, 0, ST_OK, 1, 100));
    // restart in the middle of a run
    plan_item(REQ_START, 0, 0, 0, 0);
    plan_item(REQ_TICK, 2500, 0, 0, 9);
    plan_item(REQ_START, 0, 0, 0, 10);
    plan_item(REQ_TICK, 4000, 0, 0, 11);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!in_cfg) settle();
        in_cfg = 1'b1;
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        in_cfg = 1'b0;
        dir_items++;
        offer_item(plan[i].it, plan[i].known, plan[i].res);
      end
    end

    // random runs under six register settings and three pacing modes
    for (p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: program_all(20000, 4000, 1000, 300, 256, 128, 32, 64);
        1: program_all(1, 0, 0, 0, 0, 0, 0, 0);
        2: program_all(8388607, 65535, 65535, 65535, 511, 511, 511, 511);
        5: program_all(50000, 8000, 2000, 100, 200, 90, 20, 3);
        default: program_all($urandom_range(1, 200000), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 511), $urandom_range(0, 511),
                             $urandom_range(0, 511), $urandom_range(0, 511));
      endcase
      if (p < 2) set_pace(9, 70);
      else if (p < 4) set_pace(70, 9);
      else set_pace(0, 0);
      goal = live_items + PHASE_ITEMS;
      while (live_items < goal) begin
        if (p == 0 && !held && live_items + PHASE_ITEMS > goal + 60) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (p == 3 && !paused && live_items + PHASE_ITEMS / 2 > goal) begin
          settle();
          paused = 1'b1;
        end
        dose_batch();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d directed items and %0d live items over eight register settings,",
             dir_items, live_items);
    $display("with faults, aborts, restarts, throttled and wrapped steps; %0d results checked",
             results_seen);
    if (mismatches == 0) begin
      $display("staged_mass_dosing_controller test passed");
    end else begin
      $display("staged_mass_dosing_controller test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #1000000;
    $display("staged_mass_dosing_controller test failed");
    $finish;
  end

endmodule
